FILE: rtl/bsd_pkg.sv
// bsd_pkg: types and constants shared by the bitmap stream decoder
// used by bsd_parser, bsd_pipe and bmp_stream_decoder
`timescale 1ns / 1ps

package bsd_pkg;

	localparam int MAX_WIDTH       = 4096;
	localparam int MAX_HEIGHT      = 4096;
	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

	localparam logic [15:0] BM_SIGNATURE = 16'h4D42;

	localparam logic [10:0] OFS_SIG_HI  = 11'd1;
	localparam logic [10:0] OFS_WIDTH   = 11'd18;
	localparam logic [10:0] OFS_HEIGHT  = 11'd22;
	localparam logic [10:0] OFS_DEPTH   = 11'd28;
	localparam logic [10:0] HEADER_LAST = 11'd53;
	localparam logic [10:0] MASK_LAST   = 11'd11;
	localparam logic [10:0] PAL_LAST    = 11'(PALETTE_ENTRIES * 4 - 1);

	localparam logic [1:0] ST_PIXEL   = 2'd0;
	localparam logic [1:0] ST_BAD_SIG = 2'd1;
	localparam logic [1:0] ST_TRUNC   = 2'd2;
	localparam logic [1:0] ST_UNSUP   = 2'd3;

	localparam logic [1:0] FMT_GRAY   = 2'd1;
	localparam logic [1:0] FMT_RGB565 = 2'd2;
	localparam logic [1:0] FMT_RGB888 = 2'd3;

	// luma weights in thousandths, divide by 1000 as multiply by reciprocal
	localparam logic [17:0] LUMA_W0    = 18'd299;
	localparam logic [17:0] LUMA_W1    = 18'd587;
	localparam logic [17:0] LUMA_W2    = 18'd114;
	localparam logic [36:0] LUMA_RECIP = 37'd268436;
	localparam int          LUMA_SHIFT = 28;

	typedef enum logic [5:0] {
		PH_IDLE    = 6'b000001,
		PH_HEADER  = 6'b000010,
		PH_MASKS   = 6'b000100,
		PH_PALETTE = 6'b001000,
		PH_PIXELS  = 6'b010000,
		PH_PAD     = 6'b100000
	} phase_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  status;
		logic [11:0] x;
		logic [11:0] y;
		logic [23:0] value;
		logic [1:0]  fmt;
		logic        last;
		logic        gray;
	} result_t;

endpackage

FILE: rtl/bsd_ram.sv
// bsd_ram: generic single-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module bsd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/bsd_parser.sv
// bsd_parser: header, mask, palette and pixel parsing state machine
// depends on bsd_pkg; writes the palette into bsd_ram
`timescale 1ns / 1ps

module bsd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       in_byte,
	input  logic             file_start,
	input  logic             file_last,
	output bsd_pkg::result_t res,
	output logic             pal_we,
	output logic [7:0]       pal_waddr,
	output logic [23:0]      pal_wdata
);
	import bsd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [10:0] idx_q, idx_d;
	logic [12:0] width_q, width_d;
	logic        width_big_q, width_big_d;
	logic [12:0] height_q, height_d;
	logic        height_big_q, height_big_d;
	logic [7:0]  depth_lo_q, depth_lo_d;
	logic        depth_hi_q, depth_hi_d;
	logic [1:0]  bpp_q, bpp_d;
	logic [15:0] partial_q, partial_d;
	logic [1:0]  bip_q, bip_d;
	logic [11:0] col_q, col_d;
	logic [11:0] row_q, row_d;
	logic [1:0]  pad_q, pad_d;
	logic [1:0]  row_pad_q, row_pad_d;
	logic [15:0] pal_lo_q, pal_lo_d;

	logic        fail;
	logic [1:0]  fail_st;
	logic        pix_case;
	logic [1:0]  fmt;
	logic        fmt_ok;
	logic        w_ok;
	logic        h_ok;
	logic        col_end;
	logic        final_px;

	always_comb begin
		phase_d      = phase_q;
		idx_d        = idx_q;
		width_d      = width_q;
		width_big_d  = width_big_q;
		height_d     = height_q;
		height_big_d = height_big_q;
		depth_lo_d   = depth_lo_q;
		depth_hi_d   = depth_hi_q;
		bpp_d        = bpp_q;
		partial_d    = partial_q;
		bip_d        = bip_q;
		col_d        = col_q;
		row_d        = row_q;
		pad_d        = pad_q;
		row_pad_d    = row_pad_q;
		pal_lo_d     = pal_lo_q;
		res          = '0;
		pal_we       = 1'b0;
		pal_waddr    = idx_q[9:2];
		pal_wdata    = {in_byte, pal_lo_q};
		fail         = 1'b0;
		fail_st      = ST_PIXEL;
		pix_case     = 1'b0;
		fmt          = depth_lo_q[4:3];
		fmt_ok       = 1'b0;
		w_ok         = 1'b0;
		h_ok         = 1'b0;
		col_end      = 1'b0;
		final_px     = 1'b0;

		if (accept && (file_start || phase_q != PH_IDLE)) begin
			if (file_start) begin
				phase_d      = PH_HEADER;
				idx_d        = '0;
				width_d      = '0;
				width_big_d  = 1'b0;
				height_d     = '0;
				height_big_d = 1'b0;
				depth_lo_d   = '0;
				depth_hi_d   = 1'b0;
				bpp_d        = '0;
				partial_d    = '0;
				bip_d        = '0;
				col_d        = '0;
				row_d        = '0;
				pad_d        = '0;
				row_pad_d    = '0;
			end

			unique case (phase_d)
				PH_HEADER: begin
					if (idx_d == '0) begin
						partial_d = {8'd0, in_byte};
					end else if (idx_d == OFS_SIG_HI) begin
						if ({in_byte, partial_d[7:0]} != BM_SIGNATURE) begin
							fail    = 1'b1;
							fail_st = ST_BAD_SIG;
						end
					end else if (idx_d == OFS_WIDTH) begin
						width_d[7:0] = in_byte;
					end else if (idx_d == OFS_WIDTH + 11'd1) begin
						width_d[12:8] = in_byte[4:0];
						width_big_d   = width_big_d | (|in_byte[7:5]);
					end else if (idx_d == OFS_WIDTH + 11'd2 || idx_d == OFS_WIDTH + 11'd3) begin
						width_big_d = width_big_d | (|in_byte);
					end else if (idx_d == OFS_HEIGHT) begin
						height_d[7:0] = in_byte;
					end else if (idx_d == OFS_HEIGHT + 11'd1) begin
						height_d[12:8] = in_byte[4:0];
						height_big_d   = height_big_d | (|in_byte[7:5]);
					end else if (idx_d == OFS_HEIGHT + 11'd2 || idx_d == OFS_HEIGHT + 11'd3) begin
						height_big_d = height_big_d | (|in_byte);
					end else if (idx_d == OFS_DEPTH) begin
						depth_lo_d = in_byte;
					end else if (idx_d == OFS_DEPTH + 11'd1) begin
						depth_hi_d = depth_hi_d | (|in_byte);
					end

					if (!fail) begin
						if (idx_d >= HEADER_LAST) begin
							fmt    = depth_lo_d[4:3];
							fmt_ok = !depth_hi_d && depth_lo_d[7:5] == 3'd0 && fmt != 2'd0;
							w_ok   = !width_big_d && width_d != '0
								&& width_d <= 13'(MAX_WIDTH);
							h_ok   = !height_big_d && height_d != '0
								&& height_d <= 13'(MAX_HEIGHT);
							if (!(fmt_ok && w_ok && h_ok)) begin
								fail    = 1'b1;
								fail_st = ST_UNSUP;
							end else begin
								bpp_d     = fmt;
								row_pad_d = 2'(2'd0 - 2'(width_d[1:0] * fmt));
								row_d     = 12'(height_d - 13'd1);
								col_d     = '0;
								partial_d = '0;
								bip_d     = '0;
								idx_d     = '0;
								priority case (fmt)
									FMT_RGB565: phase_d = PH_MASKS;
									FMT_GRAY:   phase_d = PH_PALETTE;
									default:    phase_d = PH_PIXELS;
								endcase
							end
						end else begin
							idx_d = idx_d + 11'd1;
						end
					end
				end

				PH_MASKS: begin
					if (idx_d >= MASK_LAST) begin
						idx_d   = '0;
						phase_d = PH_PIXELS;
					end else begin
						idx_d = idx_d + 11'd1;
					end
				end

				PH_PALETTE: begin
					unique case (idx_d[1:0])
						2'd0:    pal_lo_d[7:0]  = in_byte;
						2'd1:    pal_lo_d[15:8] = in_byte;
						2'd2:    pal_we         = 1'b1;
						default: ;
					endcase
					if (idx_d >= PAL_LAST) begin
						idx_d   = '0;
						phase_d = PH_PIXELS;
					end else begin
						idx_d = idx_d + 11'd1;
					end
				end

				PH_PIXELS: begin
					if ({1'b0, bip_d} + 3'd1 < {1'b0, bpp_d}) begin
						if (bip_d[0]) begin
							partial_d[15:8] = in_byte;
						end else begin
							partial_d[7:0] = in_byte;
						end
						bip_d = bip_d + 2'd1;
					end else begin
						pix_case  = 1'b1;
						res.x     = col_d;
						res.y     = row_d;
						res.fmt   = bpp_d;
						res.gray  = (bpp_d == FMT_GRAY);
						if (bpp_d == FMT_RGB565) begin
							res.value = {8'd0, in_byte, partial_d[7:0]};
						end else if (bpp_d == FMT_RGB888) begin
							res.value = {in_byte, partial_d};
						end else begin
							res.value = '0;
						end
						partial_d = '0;
						bip_d     = '0;
						col_end   = ({1'b0, col_d} + 13'd1) >= width_d;
						final_px  = (row_d == '0) && col_end;
						if (col_end) begin
							col_d = '0;
							if (final_px) begin
								phase_d = PH_IDLE;
							end else begin
								row_d = row_d - 12'd1;
								if (row_pad_d != 2'd0) begin
									pad_d   = row_pad_d;
									phase_d = PH_PAD;
								end
							end
						end else begin
							col_d = col_d + 12'd1;
						end
						res.last  = final_px;
						res.valid = 1'b1;
						if (file_last && !final_px) begin
							fail    = 1'b1;
							fail_st = ST_TRUNC;
						end
					end
				end

				PH_PAD: begin
					if (pad_d != 2'd0) begin
						pad_d = pad_d - 2'd1;
					end
					if (pad_d == 2'd0) begin
						phase_d = PH_PIXELS;
					end
				end

				default: phase_d = PH_IDLE;
			endcase

			if (!fail && !pix_case && file_last && phase_q != PH_IDLE | file_start) begin
				fail    = 1'b1;
				fail_st = ST_TRUNC;
			end

			if (fail) begin
				phase_d    = PH_IDLE;
				res        = '0;
				res.valid  = 1'b1;
				res.status = fail_st;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			idx_q        <= '0;
			width_q      <= '0;
			width_big_q  <= 1'b0;
			height_q     <= '0;
			height_big_q <= 1'b0;
			depth_lo_q   <= '0;
			depth_hi_q   <= 1'b0;
			bpp_q        <= '0;
			partial_q    <= '0;
			bip_q        <= '0;
			col_q        <= '0;
			row_q        <= '0;
			pad_q        <= '0;
			row_pad_q    <= '0;
		end else begin
			phase_q      <= phase_d;
			idx_q        <= idx_d;
			width_q      <= width_d;
			width_big_q  <= width_big_d;
			height_q     <= height_d;
			height_big_q <= height_big_d;
			depth_lo_q   <= depth_lo_d;
			depth_hi_q   <= depth_hi_d;
			bpp_q        <= bpp_d;
			partial_q    <= partial_d;
			bip_q        <= bip_d;
			col_q        <= col_d;
			row_q        <= row_d;
			pad_q        <= pad_d;
			row_pad_q    <= row_pad_d;
		end
	end

	// palette byte holding register, payload only
	always_ff @(posedge clk) begin
		pal_lo_q <= pal_lo_d;
	end

`ifndef SYNTH
	a_last_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.valid && res.last |=> phase_q == PH_IDLE)
		else $error("parser not idle after final pixel");
`endif

endmodule

FILE: rtl/bsd_pipe.sv
// bsd_pipe: result pipeline with palette luma and output register
// depends on bsd_pkg; palette read data arrives from bsd_ram alongside stage 1
`timescale 1ns / 1ps

module bsd_pipe (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  bsd_pkg::result_t res,
	input  logic [23:0]      pal_rdata,
	output logic             load_s1,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [55:0]      m_tdata,
	output logic [1:0]       m_tuser,
	output logic             m_tlast
);
	import bsd_pkg::*;

	logic        valid_s1;
	result_t     res_s1;
	logic        valid_s2;
	result_t     res_s2;
	logic [17:0] sum_s2;
	logic        out_valid_q;
	result_t     out_q;

	logic        load_s2;
	logic        load_out;
	logic [17:0] sum;
	logic [36:0] prod;

	assign load_out = !out_valid_q || m_tready;
	assign load_s2  = !valid_s2 || load_out;
	assign load_s1  = !valid_s1 || load_s2;

	assign sum = 18'(pal_rdata[7:0]) * LUMA_W0 + 18'(pal_rdata[15:8]) * LUMA_W1
		+ 18'(pal_rdata[23:16]) * LUMA_W2;
	assign prod = 37'(sum_s2) * LUMA_RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= accept && res.valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
			if (load_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			res_s1 <= res;
		end
		if (load_s2) begin
			res_s2 <= res_s1;
			sum_s2 <= sum;
		end
		if (load_out) begin
			out_q <= res_s2;
			if (res_s2.gray && res_s2.status == ST_PIXEL) begin
				out_q.value <= {16'd0, prod[LUMA_SHIFT+7:LUMA_SHIFT]};
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q.fmt, out_q.value, out_q.y, out_q.x};
	assign m_tuser  = out_q.status;
	assign m_tlast  = out_q.last;

`ifndef SYNTH
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_PIXEL |-> m_tdata == '0 && !m_tlast)
		else $error("error result carries pixel fields");
	a_gray_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_PIXEL && out_q.fmt == FMT_GRAY
		|-> out_q.value[23:8] == '0)
		else $error("gray value out of range");
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !load_s1 |=> valid_s1 && $stable(res_s1))
		else $error("stage 1 lost while stalled");
`endif

endmodule

FILE: rtl/bmp_stream_decoder.sv
// bmp_stream_decoder: top level of the bitmap stream decoder
// depends on bsd_pkg, bsd_ram, bsd_parser and bsd_pipe
`timescale 1ns / 1ps

// usage
//   s_* carries the file one byte per request: tdata is the byte, tuser marks
//   the first byte of a file and restarts parsing, tlast marks the last byte
//   available. m_* carries results: tuser is the status (pixel, bad
//   signature, truncated, unsupported), tlast marks the final pixel.
//   one byte is taken every cycle while s_tready is high; the parser result
//   and the palette ram read are registered together in stage 1, the luma
//   multiply-add in stage 2 and the reciprocal multiply in the output register.
//   bytes giving no result (header, masks, palette, padding, partial pixels)
//   only update the parser, except that palette bytes also write the ram.
//   s_tready drops only when all three result stages hold results while the
//   receiver stalls; empty stages keep taking bytes meanwhile.
//   reset clears the parser to idle and empties the pipeline; bytes are
//   ignored until one arrives with tuser set. the palette ram is not
//   cleared: every 8-bit file writes all 256 entries before its pixels.
module bmp_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte[7:0]
	input  logic        s_tuser,   // file_start
	input  logic        s_tlast,   // file_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // pixel_x[11:0], pixel_y[23:12], pixel_value[47:24],
	                               // pixel_format[49:48], zero[55:50]
	output logic [1:0]  m_tuser,   // status[1:0]
	output logic        m_tlast    // last_pixel
);
	import bsd_pkg::*;

	logic        accept;
	logic        load_s1;
	result_t     res;
	logic        pal_we;
	logic [7:0]  pal_waddr;
	logic [23:0] pal_wdata;
	logic [23:0] pal_rdata;

	assign s_tready = load_s1;
	assign accept   = s_tvalid && s_tready;

	bsd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_byte    (s_tdata),
		.file_start (s_tuser),
		.file_last  (s_tlast),
		.res        (res),
		.pal_we     (pal_we),
		.pal_waddr  (pal_waddr),
		.pal_wdata  (pal_wdata)
	);

	bsd_ram #(
		.WIDTH (24),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pal_waddr[PAL_AW-1:0]),
		.wdata (pal_wdata),
		.re    (load_s1),
		.raddr (s_tdata[PAL_AW-1:0]),
		.rdata (pal_rdata)
	);

	bsd_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.res       (res),
		.pal_rdata (pal_rdata),
		.load_s1   (load_s1),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
